### hdl/ciir_eq_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded IIR equalizer package
// Widths, the fixed Q6.26 coefficient table, state encoding and table lookups.
// ----------------------------------------------------------------------------
`default_nettype none

package ciir_eq_pkg;

    localparam int DEF_FILTER_ORDER  = 8;
    localparam int DEF_SECTION_COUNT = 4;

    localparam int SAMPLE_BITS = 24;
    localparam int EN_BITS     = 4;
    localparam int HIST_W      = 32;
    localparam int COEF_W      = 32;
    localparam int FRAC_BITS   = 8;
    localparam int FRAC_DROP   = 26;
    localparam int PROD_W      = 64;
    localparam int ACC_W       = 70;
    localparam int SEC_W       = 3;
    localparam int TAP_ARG_W   = 5;

    localparam int ROM_SECTIONS = 4;
    localparam int ROM_TAPS     = 9;
    localparam int ROM_COLS     = 2 * ROM_TAPS;

    localparam longint QS = 67108864;

    localparam longint COEF_ROM [ROM_SECTIONS][ROM_COLS] = '{
        '{ (48*QS+5000)/10000, 0, (-192*QS-5000)/10000, 0, (288*QS+5000)/10000, 0,
           (-192*QS-5000)/10000, 0, (48*QS+5000)/10000,
           (1000*QS+500)/1000, (-5708*QS-500)/1000, (14451*QS+500)/1000,
           (-23090*QS-500)/1000, (24964*QS+500)/1000, (-17711*QS-500)/1000,
           (8062*QS+500)/1000, (-2092*QS-500)/1000, (250*QS+500)/1000 },
        '{ (143*QS+5000)/10000, 0, (-571*QS-5000)/10000, 0, (856*QS+5000)/10000, 0,
           (-571*QS-5000)/10000, 0, (143*QS+5000)/10000,
           (1000*QS+500)/1000, (-3785*QS-500)/1000, (8232*QS+500)/1000,
           (-11006*QS-500)/1000, (10300*QS+500)/1000, (-6435*QS-500)/1000,
           (2538*QS+500)/1000, (-601*QS-500)/1000, (55*QS+500)/1000 },
        '{ (143*QS+5000)/10000, 0, (-571*QS-5000)/10000, 0, (856*QS+5000)/10000, 0,
           (-571*QS-5000)/10000, 0, (143*QS+5000)/10000,
           (1000*QS+500)/1000, (-2163*QS-500)/1000, (4020*QS+500)/1000,
           (-4922*QS-500)/1000, (4387*QS+500)/1000, (-2494*QS-500)/1000,
           (886*QS+500)/1000, (-182*QS-500)/1000, (17*QS+500)/1000 },
        '{ (48*QS+5000)/10000, 0, (-192*QS-5000)/10000, 0, (288*QS+5000)/10000, 0,
           (-192*QS-5000)/10000, 0, (48*QS+5000)/10000,
           (1000*QS+500)/1000, (-372*QS-500)/1000, (1129*QS+500)/1000,
           (-1621*QS-500)/1000, (1509*QS+500)/1000, (-877*QS-500)/1000,
           (311*QS+500)/1000, (-61*QS-500)/1000, (6*QS+500)/1000 }
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_DONE
    } ciir_state_t;

    function automatic logic signed [COEF_W-1:0] coef_b(input logic [1:0] sec,
                                                        input logic [TAP_ARG_W-1:0] tap);
        longint w;
        w = 0;
        if (tap < TAP_ARG_W'(ROM_TAPS))
            w = COEF_ROM[sec][tap];
        return w[COEF_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_a(input logic [1:0] sec,
                                                        input logic [TAP_ARG_W-1:0] tap);
        longint w;
        w = 0;
        if (tap < TAP_ARG_W'(ROM_TAPS))
            w = COEF_ROM[sec][tap + TAP_ARG_W'(ROM_TAPS)];
        return w[COEF_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/ciir_eq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module ciir_eq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/cascaded_iir_equalizer_top.sv
// ----------------------------------------------------------------------------
// Cascaded IIR equalizer
// Up to four direct-form-I IIR sections on one shared multiply-accumulate unit,
// with x and y histories kept in two synchronous RAMs.
// ----------------------------------------------------------------------------
// Each accepted item walks the usable sections in order: an enabled section runs
//   its MAC taps, a drain and a rounding step; a disabled one is skipped.
// Throughput: one item at a time; each enabled section holds the single MAC
//   while it runs, and a new sample is taken only back in the idle state.
// Reset: control clears at once; per-entry valid bits make histories read zero.
`default_nettype none

module cascaded_iir_equalizer_top
    import ciir_eq_pkg::*;
#(
    parameter int FILTER_ORDER  = DEF_FILTER_ORDER,
    parameter int SECTION_COUNT = DEF_SECTION_COUNT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [SAMPLE_BITS-1:0] s_axis_tdata,   // sample_in
    input  wire logic [EN_BITS-1:0]     s_axis_tuser,   // section_enable
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [SAMPLE_BITS-1:0] m_axis_tdata,   // sample_out
    output logic      [0:0]             m_axis_tuser    // saturated
);

    localparam int DEPTH    = SECTION_COUNT * FILTER_ORDER;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TAP_W    = $clog2(FILTER_ORDER + 1);
    localparam int SEC_USED = (SECTION_COUNT < EN_BITS) ? SECTION_COUNT : EN_BITS;
    localparam int Q_W      = ACC_W - FRAC_DROP;

    ciir_state_t state_reg, state_next;

    logic [SEC_W-1:0]         sec_reg, sec_next;
    logic [TAP_W-1:0]         tap_reg, tap_next;
    logic                     half_reg, half_next;
    logic [ADDR_W-1:0]        base_reg, base_next;
    logic [EN_BITS-1:0]       en_reg, en_next;
    logic signed [HIST_W-1:0] v_reg, v_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     prod_valid_reg, prod_valid_next;
    logic                     prod_sub_reg, prod_sub_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]   out_data_reg, out_data_next;
    logic                     out_sat_reg, out_sat_next;

    logic [DEPTH-1:0]         xvalid_reg, yvalid_reg;
    logic                     xrv_reg, yrv_reg;

    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr;
    logic                     x_we, y_we;
    logic [ADDR_W-1:0]        x_waddr, y_waddr;
    logic [HIST_W-1:0]        x_wdata, y_wdata;
    logic [HIST_W-1:0]        x_rdata, y_rdata;
    logic signed [HIST_W-1:0] x_hist, y_hist;

    logic                     last_tap;
    logic [TAP_ARG_W-1:0]     tap_arg;
    logic signed [COEF_W-1:0] coef_sel;
    logic signed [HIST_W-1:0] data_sel;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [Q_W-1:0]    q_val;
    logic signed [HIST_W-1:0] y_new;
    logic signed [SAMPLE_BITS:0] r_val;
    logic                     in_accept;

    ciir_eq_ram #(.WIDTH(HIST_W), .DEPTH(DEPTH)) u_xhist (
        .clk   (clk),
        .we    (x_we),
        .waddr (x_waddr),
        .wdata (x_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (x_rdata)
    );

    ciir_eq_ram #(.WIDTH(HIST_W), .DEPTH(DEPTH)) u_yhist (
        .clk   (clk),
        .we    (y_we),
        .waddr (y_waddr),
        .wdata (y_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (y_rdata)
    );

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign x_hist    = xrv_reg ? $signed(x_rdata) : '0;
    assign y_hist    = yrv_reg ? $signed(y_rdata) : '0;
    assign last_tap  = (tap_reg == TAP_W'(FILTER_ORDER));
    assign tap_arg   = TAP_ARG_W'(tap_reg);
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Operand selection for the shared multiplier
    always_comb
    begin
        if (half_reg)
            coef_sel = coef_a(sec_reg[1:0], tap_arg);
        else
            coef_sel = coef_b(sec_reg[1:0], tap_arg);
        if (tap_reg == '0)
            data_sel = v_reg;
        else if (half_reg)
            data_sel = y_hist;
        else
            data_sel = x_hist;
    end

    // Truncate toward zero, then clip to the Q24.8 range
    always_comb
    begin
        q_val = acc_reg[ACC_W-1:FRAC_DROP];
        if (acc_reg[ACC_W-1] && (acc_reg[FRAC_DROP-1:0] != '0))
            q_val = q_val + Q_W'(1);
        if (q_val[Q_W-1:HIST_W-1] == '0 || q_val[Q_W-1:HIST_W-1] == '1)
            y_new = q_val[HIST_W-1:0];
        else if (q_val[Q_W-1])
            y_new = {1'b1, {(HIST_W-1){1'b0}}};
        else
            y_new = {1'b0, {(HIST_W-1){1'b1}}};
    end

    // Drop the fraction of the output, toward zero
    always_comb
    begin
        r_val = {v_reg[HIST_W-1], v_reg[HIST_W-1:FRAC_BITS]};
        if (v_reg[HIST_W-1] && (v_reg[FRAC_BITS-1:0] != '0))
            r_val = r_val + (SAMPLE_BITS+1)'(1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sec_reg == SEC_W'(SEC_USED))
                    state_next = ST_DONE;
                else if (en_reg[sec_reg[1:0]])
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (half_reg && last_tap)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_ROUND;
            ST_ROUND:
                state_next = ST_SCAN;
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake and history memory control
    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = base_reg + ADDR_W'(tap_reg);
        x_we          = 1'b0;
        x_waddr       = base_reg + ADDR_W'(tap_reg);
        x_wdata       = x_hist;
        y_we          = 1'b0;
        y_waddr       = base_reg + ADDR_W'(tap_reg);
        y_wdata       = y_hist;
        unique case (state_reg)
            ST_IDLE:
                s_axis_tready = 1'b1;
            ST_MAC:
            begin
                if (tap_reg == '0)
                begin
                    mem_re  = 1'b1;
                    x_we    = 1'b1;
                    x_wdata = v_reg;
                end
                else if (half_reg && !last_tap)
                begin
                    mem_re = 1'b1;
                    x_we   = 1'b1;
                    y_we   = 1'b1;
                end
            end
            ST_ROUND:
            begin
                y_we    = 1'b1;
                y_waddr = base_reg;
                y_wdata = y_new;
            end
            ST_SCAN, ST_DRAIN, ST_DONE:
                s_axis_tready = 1'b0;
            default:
                s_axis_tready = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        sec_next        = sec_reg;
        tap_next        = tap_reg;
        half_next       = half_reg;
        base_next       = base_reg;
        en_next         = en_reg;
        v_next          = v_reg;
        prod_next       = PROD_W'(coef_sel) * PROD_W'(data_sel);
        prod_valid_next = (state_reg == ST_MAC);
        prod_sub_next   = (state_reg == ST_MAC) && half_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_sat_next    = out_sat_reg;
        if (!prod_valid_reg)
            acc_next = acc_reg;
        else if (prod_sub_reg)
            acc_next = acc_reg - prod_ext;
        else
            acc_next = acc_reg + prod_ext;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    v_next    = {s_axis_tdata, {FRAC_BITS{1'b0}}};
                    en_next   = s_axis_tuser;
                    sec_next  = '0;
                    base_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (sec_reg != SEC_W'(SEC_USED))
                begin
                    if (en_reg[sec_reg[1:0]])
                    begin
                        tap_next  = '0;
                        half_next = 1'b0;
                        acc_next  = '0;
                    end
                    else
                    begin
                        sec_next  = sec_reg + SEC_W'(1);
                        base_next = base_reg + ADDR_W'(FILTER_ORDER);
                    end
                end
            end
            ST_MAC:
            begin
                if (tap_reg == '0)
                begin
                    tap_next  = TAP_W'(1);
                    half_next = 1'b0;
                end
                else if (!half_reg)
                    half_next = 1'b1;
                else if (!last_tap)
                begin
                    tap_next  = tap_reg + TAP_W'(1);
                    half_next = 1'b0;
                end
            end
            ST_ROUND:
            begin
                v_next    = y_new;
                sec_next  = sec_reg + SEC_W'(1);
                base_next = base_reg + ADDR_W'(FILTER_ORDER);
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = r_val[SAMPLE_BITS-1:0];
                    out_sat_next   = (r_val[SAMPLE_BITS] != r_val[SAMPLE_BITS-1]);
                    if (r_val[SAMPLE_BITS] != r_val[SAMPLE_BITS-1])
                        out_data_next = r_val[SAMPLE_BITS] ?
                            {1'b1, {(SAMPLE_BITS-1){1'b0}}} :
                            {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                end
            end
            default:
            begin
                v_next = v_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sec_reg        <= '0;
            tap_reg        <= '0;
            half_reg       <= 1'b0;
            base_reg       <= '0;
            prod_valid_reg <= 1'b0;
            prod_sub_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            xvalid_reg     <= '0;
            yvalid_reg     <= '0;
            xrv_reg        <= 1'b0;
            yrv_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sec_reg        <= sec_next;
            tap_reg        <= tap_next;
            half_reg       <= half_next;
            base_reg       <= base_next;
            prod_valid_reg <= prod_valid_next;
            prod_sub_reg   <= prod_sub_next;
            out_valid_reg  <= out_valid_next;
            if (mem_re)
            begin
                xrv_reg <= xvalid_reg[mem_raddr];
                yrv_reg <= yvalid_reg[mem_raddr];
            end
            if (x_we)
                xvalid_reg[x_waddr] <= 1'b1;
            if (y_we)
                yvalid_reg[y_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        en_reg       <= en_next;
        v_reg        <= v_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_sat_reg;

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> (!x_we && !y_we))
        else $error("history written outside a section");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_SCAN && sec_reg == '0))
        else $error("accepted item did not start at the first section");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the done state");

    a_round_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> !prod_valid_reg)
        else $error("rounding before the last product was summed");

    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC |-> tap_reg <= TAP_W'(FILTER_ORDER))
        else $error("tap index beyond filter order");

endmodule

`default_nettype wire

### test/eq_checker.sv
// ----------------------------------------------------------------------------
// Cascaded IIR equalizer checker
// Watches both stream channels, predicts each filtered sample with a
// bit-exact model of the four fixed eighth-order sections and compares every
// returned item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eq_checker
    import ciir_eq_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [SAMPLE_BITS-1:0] s_tdata,    // sample_in
    input  wire logic [EN_BITS-1:0]     s_tuser,    // section_enable
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [SAMPLE_BITS-1:0] m_tdata,    // sample_out
    input  wire logic [0:0]             m_tuser,    // saturated
    output int                          mismatch_count,
    output int                          pending_results,
    output int                          results_checked,
    output int                          clipped_count
);

    localparam int N_SEC = 4;
    localparam int N_ORD = 8;
    localparam longint Q26_SCALE = 67108864;

    localparam logic signed [79:0] Q26_ONE  = 80'sd67108864;
    localparam logic signed [79:0] HIST_MAX = 80'sd2147483647;
    localparam logic signed [79:0] HIST_MIN = -80'sd2147483648;
    localparam logic signed [31:0] OUT_MAX  = 32'sd8388607;
    localparam logic signed [31:0] OUT_MIN  = -32'sd8388608;

    // feed-forward taps in 1e-4 units, feedback taps in 1e-3 units
    localparam int B_DESIGN [N_SEC][N_ORD+1] = '{
        '{ 48, 0, -192, 0, 288, 0, -192, 0, 48 },
        '{ 143, 0, -571, 0, 856, 0, -571, 0, 143 },
        '{ 143, 0, -571, 0, 856, 0, -571, 0, 143 },
        '{ 48, 0, -192, 0, 288, 0, -192, 0, 48 }
    };
    localparam int A_DESIGN [N_SEC][N_ORD+1] = '{
        '{ 1000, -5708, 14451, -23090, 24964, -17711, 8062, -2092, 250 },
        '{ 1000, -3785, 8232, -11006, 10300, -6435, 2538, -601, 55 },
        '{ 1000, -2163, 4020, -4922, 4387, -2494, 886, -182, 17 },
        '{ 1000, -372, 1129, -1621, 1509, -877, 311, -61, 6 }
    };

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] audio;
        logic                   clip;
    } eq_result_t;

    logic signed [31:0] b_coef [N_SEC][N_ORD+1];
    logic signed [31:0] a_coef [N_SEC][N_ORD+1];
    logic signed [31:0] x_hist [N_SEC][N_ORD];
    logic signed [31:0] y_hist [N_SEC][N_ORD];

    eq_result_t equalized_q [$];
    eq_result_t want;

    function automatic logic signed [31:0] to_q26(input longint num, input longint den);
        longint half;
        half = den / 2;
        return 32'((num * Q26_SCALE + (num < 0 ? -half : half)) / den);
    endfunction

    initial
    begin
        for (int s = 0; s < N_SEC; s++)
        begin
            for (int t = 0; t <= N_ORD; t++)
            begin
                b_coef[s][t] = to_q26(B_DESIGN[s][t], 10000);
                a_coef[s][t] = to_q26(A_DESIGN[s][t], 1000);
            end
        end
    end

    function automatic logic signed [31:0] run_section(input int sec,
                                                       input logic signed [31:0] x0);
        logic signed [79:0] acc;
        logic signed [79:0] coef_w;
        logic signed [79:0] data_w;
        logic signed [79:0] quot;
        logic signed [31:0] y;
        int k;
        coef_w = b_coef[sec][0];
        data_w = x0;
        acc = coef_w * data_w;
        for (k = 1; k <= N_ORD; k++)
        begin
            coef_w = b_coef[sec][k];
            data_w = x_hist[sec][k-1];
            acc = acc + coef_w * data_w;
            coef_w = a_coef[sec][k];
            data_w = y_hist[sec][k-1];
            acc = acc - coef_w * data_w;
        end
        quot = acc / Q26_ONE;
        if (quot > HIST_MAX)
            y = 32'sh7FFFFFFF;
        else if (quot < HIST_MIN)
            y = 32'sh80000000;
        else
            y = quot[31:0];
        for (k = N_ORD - 1; k > 0; k--)
        begin
            x_hist[sec][k] = x_hist[sec][k-1];
            y_hist[sec][k] = y_hist[sec][k-1];
        end
        x_hist[sec][0] = x0;
        y_hist[sec][0] = y;
        return y;
    endfunction

    function automatic eq_result_t equalize(input logic [SAMPLE_BITS-1:0] smp,
                                            input logic [EN_BITS-1:0] mask);
        logic signed [31:0] v;
        logic signed [31:0] r;
        eq_result_t res;
        int s;
        v = {smp, 8'h00};
        for (s = 0; s < N_SEC; s++)
        begin
            if (mask[s])
                v = run_section(s, v);
        end
        r = v / 32'sd256;
        res.clip = 1'b0;
        if (r > OUT_MAX)
        begin
            r = OUT_MAX;
            res.clip = 1'b1;
        end
        if (r < OUT_MIN)
        begin
            r = OUT_MIN;
            res.clip = 1'b1;
        end
        res.audio = r[SAMPLE_BITS-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int exp_val, input int act_val);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] MISMATCH %s at result %0d: expected %0d, got %0d",
                     $realtime, what, results_checked, exp_val, act_val);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < N_SEC; s++)
            begin
                for (int k = 0; k < N_ORD; k++)
                begin
                    x_hist[s][k] = '0;
                    y_hist[s][k] = '0;
                end
            end
            equalized_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                equalized_q.push_back(equalize(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                if (equalized_q.size() == 0)
                    flag_mismatch("result with nothing pending, sample_out", 0,
                                  int'($signed(m_tdata)));
                else
                begin
                    want = equalized_q.pop_front();
                    if (m_tdata !== want.audio)
                        flag_mismatch("sample_out", int'($signed(want.audio)),
                                      int'($signed(m_tdata)));
                    if (m_tuser[0] !== want.clip)
                        flag_mismatch("saturated", int'(want.clip), int'(m_tuser[0]));
                    if (m_tuser[0] === 1'b1)
                        clipped_count++;
                    results_checked++;
                end
            end
        end
        pending_results <= equalized_q.size();
    end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// Cascaded IIR equalizer testbench
// Drives directed and random audio samples with every section mask through the
// equalizer, idles both stream sides at random and leaves checking to the
// checker; reports the verdict once all predicted samples have come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import ciir_eq_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int SETTLE_CYCLES = 100;

    localparam logic [SAMPLE_BITS-1:0] DIRECTED_SAMPLES [5] = '{
        24'h000001, 24'h7FFFFF, 24'h800000, 24'h555555, 24'hAAAAAA
    };

    typedef enum int {
        SIG_SMALL,
        SIG_FULL,
        SIG_RAIL,
        SIG_STEP
    } sig_style_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [SAMPLE_BITS-1:0] s_axis_tdata;   // sample_in
    logic [EN_BITS-1:0]     s_axis_tuser;   // section_enable
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [SAMPLE_BITS-1:0] m_axis_tdata;   // sample_out
    logic [0:0]             m_axis_tuser;   // saturated

    int mismatch_count;
    int pending_results;
    int results_checked;
    int clipped_count;
    int items_sent;
    int stall_left;
    bit calm;

    cascaded_iir_equalizer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    eq_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .s_tuser         (s_axis_tuser),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .m_tuser         (m_axis_tuser),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .clipped_count   (clipped_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input sig_style_t style,
                                                           input logic [SAMPLE_BITS-1:0] prev);
        int amp;
        logic [SAMPLE_BITS-1:0] rails [4];
        rails = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
        case (style)
            SIG_SMALL:
            begin
                amp = 1 << $urandom_range(16, 2);
                return SAMPLE_BITS'(int'($urandom_range(2 * amp)) - amp);
            end
            SIG_RAIL:
                return rails[$urandom_range(3)];
            SIG_STEP:
                return ($urandom_range(4) == 0) ? SAMPLE_BITS'($urandom) : prev;
            default:
                return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // hold valid low for a random gap, then offer one item until taken
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp,
                               input logic [EN_BITS-1:0] mask);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= mask;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // drop valid and hold until every predicted sample has returned
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(99) < 20)
                stall_left = draw_gap();
        end
    end

    initial
    begin
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int i;
        int seg_len;
        int random_sent;
        logic [EN_BITS-1:0] seg_mask;
        logic [EN_BITS-1:0] mask;
        logic [SAMPLE_BITS-1:0] level;
        sig_style_t style;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        calm          = 1'b0;
        items_sent    = 0;
        random_sent   = 0;
        level         = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // bypass of all sections at the sample extremes
        send_sample(24'h000000, 4'h0);
        send_sample(24'h7FFFFF, 4'h0);
        send_sample(24'h800000, 4'h0);
        send_sample(24'hFFFFFF, 4'h0);
        for (i = 1; i < 16; i++)
            send_sample(DIRECTED_SAMPLES[i % 5], EN_BITS'(i));
        // drive the first section hard toward runaway
        repeat (5) send_sample(24'h7FFFFF, 4'h1);
        wait_drained();

        while (random_sent < RANDOM_ITEMS)
        begin
            seg_len  = $urandom_range(64, 8);
            style    = sig_style_t'($urandom_range(3));
            seg_mask = ($urandom_range(3) == 0) ? 4'hF : EN_BITS'($urandom_range(15));
            calm     = ($urandom_range(4) == 0);
            for (i = 0; i < seg_len && random_sent < RANDOM_ITEMS; i++)
            begin
                mask  = ($urandom_range(9) == 0) ? EN_BITS'($urandom_range(15)) : seg_mask;
                level = pick_sample(style, level);
                send_sample(level, mask);
                random_sent++;
                if (random_sent == RANDOM_ITEMS / 2)
                    wait_drained();
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d samples (%0d random) over all section masks and sample extremes,",
                 items_sent, random_sent);
        $display("checked %0d filtered samples, %0d clipped, %0d field mismatches.",
                 results_checked, clipped_count, mismatch_count);
        if (mismatch_count == 0 && pending_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
